>>> hw/rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared widths, opcodes, error codes and controller/datapath bundles for the
// stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int DEF_STACK_DEPTH = 1024;
  localparam int DEF_CODE_DEPTH  = 4096;

  localparam int OPW = 5;
  localparam int IW  = 32;
  localparam int WW  = 64;
  localparam int TW  = 12;
  localparam int EW  = 2;

  localparam logic [OPW-1:0] OP_HALT     = 5'd0;
  localparam logic [OPW-1:0] OP_IMM_I    = 5'd1;
  localparam logic [OPW-1:0] OP_IMM_F    = 5'd2;
  localparam logic [OPW-1:0] OP_CALL     = 5'd3;
  localparam logic [OPW-1:0] OP_EMIT     = 5'd4;
  localparam logic [OPW-1:0] OP_FRAME    = 5'd5;
  localparam logic [OPW-1:0] OP_RET      = 5'd6;
  localparam logic [OPW-1:0] OP_JMP      = 5'd7;
  localparam logic [OPW-1:0] OP_JF       = 5'd8;
  localparam logic [OPW-1:0] OP_JF_F     = 5'd9;
  localparam logic [OPW-1:0] OP_LOAD_A   = 5'd10;
  localparam logic [OPW-1:0] OP_LOAD_B   = 5'd11;
  localparam logic [OPW-1:0] OP_STORE_A  = 5'd12;
  localparam logic [OPW-1:0] OP_STORE_B  = 5'd13;
  localparam logic [OPW-1:0] OP_IADD     = 5'd14;
  localparam logic [OPW-1:0] OP_DADD     = 5'd15;
  localparam logic [OPW-1:0] OP_ILT      = 5'd16;
  localparam logic [OPW-1:0] OP_DLT      = 5'd17;

  localparam logic [EW-1:0] ERR_NONE = 2'd0;
  localparam logic [EW-1:0] ERR_OVF  = 2'd1;
  localparam logic [EW-1:0] ERR_UNF  = 2'd2;
  localparam logic [EW-1:0] ERR_OP   = 2'd3;

  localparam logic [WW-1:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [WW-1:0] DBL_QNAN = 64'hFFF8_0000_0000_0000;

  typedef struct packed {
    logic load_item;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic fp_start;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic skip;
    logic need_a;
    logic need_b;
    logic is_fadd;
    logic fp_done;
    logic res_free;
  } ctl_sts_t;

endpackage

>>> hw/rtl/smx_fadd.sv
// ----------------------------------------------------------------------------
// smx_fadd
// Multi-cycle IEEE double adder, round to nearest even, one-bit-a-cycle
// normalisation.
// ----------------------------------------------------------------------------
module smx_fadd (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [smx_pkg::WW-1:0] a,
  input  logic [smx_pkg::WW-1:0] b,
  output logic                   done,
  output logic [smx_pkg::WW-1:0] res
);
  import smx_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_UNPK = 3'd1;
  localparam logic [2:0] F_ALGN = 3'd2;
  localparam logic [2:0] F_ADD  = 3'd3;
  localparam logic [2:0] F_NORM = 3'd4;
  localparam logic [2:0] F_RND  = 3'd5;

  logic [2:0]    state;
  logic [WW-1:0] xa, xb;
  logic          sgn, eff_sub, zsign;
  logic [11:0]   e_big, diff, e;
  logic [55:0]   m_big, m_sm;
  logic [56:0]   sum;

  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [11:0] ea_e, eb_e;
  logic [55:0] ma, mb, sh, msk;
  logic        sticky, up;
  logic [10:0] efield;

  always_comb begin
    ea    = xa[62:52];
    eb    = xb[62:52];
    fa    = xa[51:0];
    fb    = xb[51:0];
    a_nan = (ea == 11'h7FF) && (fa != 52'd0);
    b_nan = (eb == 11'h7FF) && (fb != 52'd0);
    a_inf = (ea == 11'h7FF) && (fa == 52'd0);
    b_inf = (eb == 11'h7FF) && (fb == 52'd0);
    swap  = xb[62:0] > xa[62:0];
    ea_e  = (ea == 11'd0) ? 12'd1 : {1'b0, ea};
    eb_e  = (eb == 11'd0) ? 12'd1 : {1'b0, eb};
    ma    = {ea != 11'd0, fa, 3'b000};
    mb    = {eb != 11'd0, fb, 3'b000};
    sh     = m_sm >> diff[5:0];
    msk    = ~({56{1'b1}} << diff[5:0]);
    sticky = |(m_sm & msk);
    efield = sum[55] ? e[10:0] : 11'd0;
    up     = sum[2] & (sum[1] | sum[0] | sum[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (start) begin
            xa    <= a;
            xb    <= b;
            state <= F_UNPK;
          end
        end
        F_UNPK: begin
          zsign   <= xa[63] & xb[63];
          eff_sub <= xa[63] ^ xb[63];
          if (a_nan) begin
            res <= xa | 64'h0008_0000_0000_0000;
            done <= 1'b1;
            state <= F_IDLE;
          end else if (b_nan) begin
            res <= xb | 64'h0008_0000_0000_0000;
            done <= 1'b1;
            state <= F_IDLE;
          end else if (a_inf && b_inf && (xa[63] != xb[63])) begin
            res <= DBL_QNAN;
            done <= 1'b1;
            state <= F_IDLE;
          end else if (a_inf) begin
            res <= xa;
            done <= 1'b1;
            state <= F_IDLE;
          end else if (b_inf) begin
            res <= xb;
            done <= 1'b1;
            state <= F_IDLE;
          end else begin
            if (swap) begin
              sgn   <= xb[63];
              e_big <= eb_e;
              m_big <= mb;
              m_sm  <= ma;
              diff  <= eb_e - ea_e;
            end else begin
              sgn   <= xa[63];
              e_big <= ea_e;
              m_big <= ma;
              m_sm  <= mb;
              diff  <= ea_e - eb_e;
            end
            state <= F_ALGN;
          end
        end
        F_ALGN: begin
          if (diff >= 12'd56) begin
            m_sm <= {55'd0, |m_sm};
          end else begin
            m_sm <= {sh[55:1], sh[0] | sticky};
          end
          state <= F_ADD;
        end
        F_ADD: begin
          sum   <= eff_sub ? ({1'b0, m_big} - {1'b0, m_sm}) : ({1'b0, m_big} + {1'b0, m_sm});
          e     <= e_big;
          state <= F_NORM;
        end
        F_NORM: begin
          if (sum == 57'd0) begin
            res   <= {zsign, 63'd0};
            done  <= 1'b1;
            state <= F_IDLE;
          end else if (sum[56]) begin
            sum   <= {1'b0, sum[56:2], sum[1] | sum[0]};
            e     <= e + 12'd1;
            state <= F_RND;
          end else if (!sum[55] && (e > 12'd1)) begin
            sum <= {sum[55:0], 1'b0};
            e   <= e - 12'd1;
          end else begin
            state <= F_RND;
          end
        end
        F_RND: begin
          if (e >= 12'd2047) begin
            res <= {sgn, 11'h7FF, 52'd0};
          end else begin
            res <= {sgn, {efield, sum[54:3]} + {62'd0, up}};
          end
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/smx_ctrl.sv
// ----------------------------------------------------------------------------
// smx_ctrl
// Instruction sequencer: decode, stack reads, execute, write back.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  smx_pkg::ctl_sts_t sts,
  output smx_pkg::ctl_cmd_t cmd
);
  import smx_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RA   = 3'd2;
  localparam logic [2:0] S_RB   = 3'd3;
  localparam logic [2:0] S_EXE  = 3'd4;
  localparam logic [2:0] S_FPW  = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;

  logic [2:0] state, state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.skip && sts.need_a) begin
          cmd.rd_a   = 1'b1;
          state_next = S_RA;
        end else begin
          state_next = S_EXE;
        end
      end
      S_RA: begin
        cmd.cap_a = 1'b1;
        if (sts.need_b) begin
          cmd.rd_b   = 1'b1;
          state_next = S_RB;
        end else begin
          state_next = S_EXE;
        end
      end
      S_RB: begin
        cmd.cap_b  = 1'b1;
        state_next = S_EXE;
      end
      S_EXE: begin
        if (!sts.skip && sts.is_fadd) begin
          cmd.fp_start = 1'b1;
          state_next   = S_FPW;
        end else begin
          state_next = S_WB;
        end
      end
      S_FPW: begin
        if (sts.fp_done) state_next = S_WB;
      end
      S_WB: begin
        if (sts.res_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/smx_dpath.sv
// ----------------------------------------------------------------------------
// smx_dpath
// Machine state, stack memory, operand registers, ALU and result register.
// ----------------------------------------------------------------------------
module smx_dpath #(
  parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH,
  parameter int CODE_DEPTH  = smx_pkg::DEF_CODE_DEPTH,
  parameter int CW          = $clog2(STACK_DEPTH + 1),
  parameter int PW          = $clog2(CODE_DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  smx_pkg::ctl_cmd_t              cmd,
  output smx_pkg::ctl_sts_t              sts,
  input  logic [smx_pkg::TW-1:0]         cfg_data,
  input  logic                           cfg_we,
  input  logic [smx_pkg::OPW-1:0]        op,
  input  logic signed [smx_pkg::IW-1:0]  int_arg,
  input  logic [smx_pkg::WW-1:0]         float_arg,
  input  logic [smx_pkg::TW-1:0]         target,
  input  logic                           ext_kind,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [PW-1:0]                  next_pc,
  output logic                           halted,
  output logic                           out_valid,
  output logic [smx_pkg::WW-1:0]         out_value,
  output logic                           out_is_float,
  output logic [smx_pkg::EW-1:0]         error_code,
  output logic [CW-1:0]                  stack_depth
);
  import smx_pkg::*;

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int NW = 34;

  logic [WW-1:0] mem [STACK_DEPTH];
  logic [WW-1:0] rd_data, reg_a, reg_b;

  logic [CW-1:0] count, cnt_n;
  logic [SW-1:0] fp, fp_n;
  logic [PW-1:0] pc, pc_n, pc1;
  logic          stopped, stop_n;
  logic [EW-1:0] err, err_n;

  logic [OPW-1:0] op_q;
  logic [IW-1:0]  arg_q;
  logic [WW-1:0]  farg_q;
  logic [PW-1:0]  tgt_q;
  logic           kind_q;

  logic signed [NW-1:0] cs, fs, as_s, depth_s, en_nc, rt_nc;
  logic [EW-1:0] flt;
  logic          full;
  logic [SW-1:0] fa, c_addr, c_m1, c_m2, addr_a, addr_b, ra, wa;
  logic          we, ov, ofl;
  logic [WW-1:0] wd, oval, bin_res, f_res;
  logic          f_done, f_lt, a_mag_lt, b_mag_lt, a_nan, b_nan, both_zero;

  smx_fadd u_fadd (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.fp_start),
    .a     (reg_a),
    .b     (reg_b),
    .done  (f_done),
    .res   (f_res)
  );

  always_comb begin
    cs      = $signed({{(NW-CW){1'b0}}, count});
    fs      = $signed({{(NW-SW){1'b0}}, fp});
    as_s    = $signed({{(NW-IW){arg_q[IW-1]}}, arg_q});
    depth_s = NW'(STACK_DEPTH);
    en_nc   = cs + NW'(1) + as_s;
    rt_nc   = fs - as_s - NW'(1);
    full    = count >= CW'(STACK_DEPTH);
    fa      = fp + arg_q[SW-1:0];
    c_addr  = count[SW-1:0];
    c_m1    = SW'(count - CW'(1));
    c_m2    = SW'(count - CW'(2));
    pc1     = pc + PW'(1);

    flt = ERR_NONE;
    case (op_q)
      OP_HALT, OP_JMP: flt = ERR_NONE;
      OP_IMM_I, OP_IMM_F, OP_CALL, OP_LOAD_A, OP_LOAD_B: begin
        if (full) flt = ERR_OVF;
      end
      OP_EMIT, OP_JF, OP_JF_F, OP_STORE_A, OP_STORE_B: begin
        if (count == CW'(0)) flt = ERR_UNF;
      end
      OP_FRAME: begin
        if (full) flt = ERR_OVF;
        else if (en_nc < 0) flt = ERR_UNF;
        else if (en_nc > depth_s) flt = ERR_OVF;
      end
      OP_RET: begin
        if (fp == SW'(0)) flt = ERR_UNF;
        else if (rt_nc < 0) flt = ERR_UNF;
        else if (rt_nc > depth_s) flt = ERR_OVF;
      end
      OP_IADD, OP_DADD, OP_ILT, OP_DLT: begin
        if (count < CW'(2)) flt = ERR_UNF;
      end
      default: flt = ERR_OP;
    endcase

    addr_a = c_m1;
    addr_b = c_m1;
    case (op_q)
      OP_LOAD_A, OP_LOAD_B: addr_a = fa;
      OP_IADD, OP_DADD, OP_ILT, OP_DLT: addr_a = c_m2;
      OP_RET: begin
        addr_a = fp - SW'(1);
        addr_b = fp;
      end
      default: addr_a = c_m1;
    endcase
    ra = cmd.rd_b ? addr_b : addr_a;

    sts.skip     = stopped || (flt != ERR_NONE) || (op_q == OP_HALT);
    sts.need_b   = (op_q == OP_IADD) || (op_q == OP_DADD) || (op_q == OP_ILT) ||
                   (op_q == OP_DLT) || (op_q == OP_RET);
    sts.need_a   = sts.need_b || (op_q == OP_EMIT) || (op_q == OP_JF) ||
                   (op_q == OP_JF_F) || (op_q == OP_STORE_A) || (op_q == OP_STORE_B) ||
                   (op_q == OP_LOAD_A) || (op_q == OP_LOAD_B);
    sts.is_fadd  = op_q == OP_DADD;
    sts.fp_done  = f_done;
    sts.res_free = !res_valid || res_ready;

    a_nan     = (reg_a[62:52] == 11'h7FF) && (reg_a[51:0] != 52'd0);
    b_nan     = (reg_b[62:52] == 11'h7FF) && (reg_b[51:0] != 52'd0);
    both_zero = (reg_a[62:0] == 63'd0) && (reg_b[62:0] == 63'd0);
    a_mag_lt  = reg_a[62:0] < reg_b[62:0];
    b_mag_lt  = reg_b[62:0] < reg_a[62:0];
    if (a_nan || b_nan || both_zero) f_lt = 1'b0;
    else if (reg_a[63] != reg_b[63]) f_lt = reg_a[63];
    else if (reg_a[63]) f_lt = b_mag_lt;
    else f_lt = a_mag_lt;

    case (op_q)
      OP_IADD: bin_res = {32'd0, reg_a[31:0] + reg_b[31:0]};
      OP_DADD: bin_res = f_res;
      OP_ILT:  bin_res = {63'd0, $signed(reg_a[31:0]) < $signed(reg_b[31:0])};
      default: bin_res = f_lt ? DBL_ONE : '0;
    endcase

    cnt_n  = count;
    fp_n   = fp;
    pc_n   = pc;
    stop_n = stopped;
    err_n  = err;
    we     = 1'b0;
    wa     = c_addr;
    wd     = '0;
    ov     = 1'b0;
    ofl    = 1'b0;
    oval   = '0;
    if (!stopped) begin
      if (flt != ERR_NONE) begin
        stop_n = 1'b1;
        err_n  = flt;
      end else begin
        pc_n = pc1;
        case (op_q)
          OP_HALT: begin
            stop_n = 1'b1;
            pc_n   = pc;
          end
          OP_IMM_I, OP_IMM_F, OP_CALL, OP_LOAD_A, OP_LOAD_B: begin
            we    = 1'b1;
            cnt_n = count + CW'(1);
            case (op_q)
              OP_IMM_I: wd = {32'd0, arg_q};
              OP_IMM_F: wd = farg_q;
              OP_CALL: begin
                wd   = WW'(pc1);
                pc_n = tgt_q;
              end
              default: wd = reg_a;
            endcase
          end
          OP_EMIT: begin
            cnt_n = count - CW'(1);
            ov    = 1'b1;
            ofl   = kind_q;
            oval  = kind_q ? reg_a : {32'd0, reg_a[31:0]};
          end
          OP_FRAME: begin
            we    = 1'b1;
            wd    = WW'(fp);
            fp_n  = c_addr;
            cnt_n = CW'(en_nc);
          end
          OP_RET: begin
            pc_n  = PW'(reg_a);
            fp_n  = SW'(reg_b);
            cnt_n = CW'(rt_nc);
          end
          OP_JMP: pc_n = tgt_q;
          OP_JF: begin
            cnt_n = count - CW'(1);
            if (reg_a[31:0] == 32'd0) pc_n = tgt_q;
          end
          OP_JF_F: begin
            cnt_n = count - CW'(1);
            if (reg_a[62:0] == 63'd0) pc_n = tgt_q;
          end
          OP_STORE_A, OP_STORE_B: begin
            we    = 1'b1;
            wa    = fa;
            wd    = reg_a;
            cnt_n = count - CW'(1);
          end
          default: begin
            we    = 1'b1;
            wa    = c_m2;
            wd    = bin_res;
            cnt_n = count - CW'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && we) mem[wa] <= wd;
    if (cmd.rd_a || cmd.rd_b) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= op;
      arg_q  <= int_arg;
      farg_q <= float_arg;
      tgt_q  <= PW'(target);
      kind_q <= ext_kind;
    end
    if (cmd.cap_a) reg_a <= rd_data;
    if (cmd.cap_b) reg_b <= rd_data;
    if (cmd.commit) begin
      next_pc      <= pc_n;
      halted       <= stop_n;
      out_valid    <= ov;
      out_value    <= oval;
      out_is_float <= ofl;
      error_code   <= err_n;
      stack_depth  <= cnt_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      fp        <= '0;
      pc        <= '0;
      stopped   <= 1'b0;
      err       <= ERR_NONE;
      res_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count   <= cnt_n;
        fp      <= fp_n;
        pc      <= pc_n;
        stopped <= stop_n;
        err     <= err_n;
      end
      if (cfg_we) pc <= PW'(cfg_data);
      if (cmd.commit) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stopped flag cleared");
  a_err_stops: assert property (@(posedge clk) disable iff (rst)
    (err != ERR_NONE) |-> stopped)
    else $error("error latched without stop");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !cmd.commit)
    else $error("result overwritten");
`endif

endmodule

>>> hw/rtl/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-machine instruction per request against a framed stack.
// ----------------------------------------------------------------------------
// One request is taken at a time. Push, jump, call, enter and halt, and any
// request that faults or reaches a stopped machine, go from decode straight
// to execute and write-back; single-operand pops, loads and stores first read
// one stack word; binary int ops, double compare and return read two, each
// stack word in turn on the single read port of the stack memory. Double add
// runs through a multi-cycle adder whose normalisation shifts one bit a cycle.
// The next request is taken the cycle after a result is registered, and a
// finished result waits in an output register while that request is accepted.
module stack_machine_executor #(
  parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH,
  parameter int CODE_DEPTH  = smx_pkg::DEF_CODE_DEPTH,
  parameter int CW          = $clog2(STACK_DEPTH + 1),
  parameter int PW          = $clog2(CODE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smx_pkg::TW-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smx_pkg::OPW-1:0]       op,
  input  logic signed [smx_pkg::IW-1:0] int_arg,
  input  logic [smx_pkg::WW-1:0]        float_arg,
  input  logic [smx_pkg::TW-1:0]        target,
  input  logic                          ext_kind,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [PW-1:0]                 next_pc,
  output logic                          halted,
  output logic                          out_valid,
  output logic [smx_pkg::WW-1:0]        out_value,
  output logic                          out_is_float,
  output logic [smx_pkg::EW-1:0]        error_code,
  output logic [CW-1:0]                 stack_depth
);
  import smx_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  smx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smx_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .CODE_DEPTH  (CODE_DEPTH),
    .CW          (CW),
    .PW          (PW)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_data     (cfg_data),
    .cfg_we       (cfg_we),
    .op           (op),
    .int_arg      (int_arg),
    .float_arg    (float_arg),
    .target       (target),
    .ext_kind     (ext_kind),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .next_pc      (next_pc),
    .halted       (halted),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_is_float (out_is_float),
    .error_code   (error_code),
    .stack_depth  (stack_depth)
  );

endmodule
